// File: rtl/deq_pkg.sv
// Shared types and constants for the double-ended queue.
package deq_pkg;

  // Default geometry of the queue.
  localparam int DefaultDepth = 16;
  localparam int DefaultValueWidth = 32;

  // Action codes carried by an input transaction.
  typedef enum logic [2:0] {
    ACT_PUSH_FRONT = 3'd0,
    ACT_PUSH_BACK  = 3'd1,
    ACT_POP_FRONT  = 3'd2,
    ACT_POP_BACK   = 3'd3,
    ACT_PEEK_FRONT = 3'd4,
    ACT_PEEK_BACK  = 3'd5
  } act_t;

  // Status codes returned with every result.
  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_UNDER = 2'd1,
    ST_OVER  = 2'd2
  } status_t;

  // Per-cycle command broadcast to every cell of the chain.
  typedef struct packed {
    logic push_front;
    logic pop_front;
    logic push_back;
  } cell_ctl_t;

endpackage

// File: rtl/double_ended_queue.sv
// Double-ended queue built as a chain of shifting cells, front at cell zero.
// The result of a transaction appears with done in the cycle after it is accepted.
// Throughput: one transaction per cycle; busy stays low.
// Reset (synchronous, rst high) empties the queue and clears done; entries are not cleared.
// The receiver cannot stall: each result is shown for exactly one cycle.
module double_ended_queue #(
  parameter int DEPTH = deq_pkg::DefaultDepth,
  parameter int VALUE_WIDTH = deq_pkg::DefaultValueWidth,
  localparam int CNT_W = $clog2(DEPTH + 1)
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   start,
  output logic                   busy,
  input  logic [2:0]             action,
  input  logic [VALUE_WIDTH-1:0] push_value,
  output logic                   done,
  output logic [VALUE_WIDTH-1:0] read_value,
  output logic [1:0]             status,
  output logic                   is_empty,
  output logic                   is_full,
  output logic [CNT_W-1:0]       entry_count
);

  localparam logic [CNT_W-1:0] DepthC = CNT_W'(DEPTH);
  localparam logic [CNT_W-1:0] OneC = CNT_W'(1);

  logic [CNT_W-1:0]       count;
  logic [CNT_W-1:0]       count_next;
  logic [VALUE_WIDTH-1:0] cell_val [DEPTH];
  logic [VALUE_WIDTH-1:0] cell_tap [DEPTH];
  logic [VALUE_WIDTH-1:0] back_value;
  logic [VALUE_WIDTH-1:0] rd_next;
  deq_pkg::status_t       st_next;
  deq_pkg::cell_ctl_t     ctl;
  logic                   accept;
  logic                   q_empty;
  logic                   q_full;

  assign busy = 1'b0;
  assign accept = start && !busy;
  assign q_empty = (count == '0);
  assign q_full = (count == DepthC);

  // Chain of cells; each takes its neighbors' entries when the queue shifts.
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic [VALUE_WIDTH-1:0] prev_v;
    logic [VALUE_WIDTH-1:0] next_v;
    if (i == 0) begin : g_first
      assign prev_v = push_value;
    end else begin : g_mid
      assign prev_v = cell_val[i-1];
    end
    if (i == DEPTH - 1) begin : g_last
      assign next_v = '0;
    end else begin : g_inner
      assign next_v = cell_val[i+1];
    end
    deq_cell #(
      .VALUE_WIDTH(VALUE_WIDTH),
      .CNT_W(CNT_W),
      .IDX(i)
    ) u_cell (
      .clk(clk),
      .ctl(ctl),
      .count(count),
      .push_value(push_value),
      .prev_value(prev_v),
      .next_value(next_v),
      .value(cell_val[i]),
      .tap(cell_tap[i])
    );
  end

  // Only the cell holding the last entry drives its tap, so an OR collects it.
  always_comb begin
    back_value = '0;
    for (int i = 0; i < DEPTH; i++) begin
      back_value = back_value | cell_tap[i];
    end
  end

  // Decode the accepted transaction into a cell command, a new count and a result.
  always_comb begin
    ctl = '0;
    count_next = count;
    rd_next = '0;
    st_next = deq_pkg::ST_OK;
    if (accept) begin
      unique case (action)
        deq_pkg::ACT_PUSH_FRONT, deq_pkg::ACT_PUSH_BACK: begin
          if (q_full) begin
            st_next = deq_pkg::ST_OVER;
          end else begin
            ctl.push_front = (action == deq_pkg::ACT_PUSH_FRONT);
            ctl.push_back = (action == deq_pkg::ACT_PUSH_BACK);
            count_next = count + OneC;
          end
        end
        deq_pkg::ACT_POP_FRONT: begin
          if (q_empty) begin
            st_next = deq_pkg::ST_UNDER;
          end else begin
            rd_next = cell_val[0];
            ctl.pop_front = 1'b1;
            count_next = count - OneC;
          end
        end
        deq_pkg::ACT_POP_BACK: begin
          if (q_empty) begin
            st_next = deq_pkg::ST_UNDER;
          end else begin
            rd_next = back_value;
            count_next = count - OneC;
          end
        end
        deq_pkg::ACT_PEEK_FRONT: begin
          if (q_empty) begin
            st_next = deq_pkg::ST_UNDER;
          end else begin
            rd_next = cell_val[0];
          end
        end
        deq_pkg::ACT_PEEK_BACK: begin
          if (q_empty) begin
            st_next = deq_pkg::ST_UNDER;
          end else begin
            rd_next = back_value;
          end
        end
        default: begin
          // Unused action codes leave the queue alone and report ok.
        end
      endcase
    end
  end

  // Occupancy count and the done strobe.
  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
      done <= 1'b0;
    end else begin
      count <= count_next;
      done <= accept;
    end
  end

  // Result registers, loaded on every accepted transaction.
  always_ff @(posedge clk) begin
    if (accept) begin
      read_value <= rd_next;
      status <= st_next;
      is_empty <= (count_next == '0);
      is_full <= (count_next == DepthC);
      entry_count <= count_next;
    end
  end

  // The count never exceeds the queue depth.
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= DepthC) else $error("entry count beyond depth");

  // Every accepted transaction yields exactly one result in the next cycle.
  a_done_follows: assert property (@(posedge clk) disable iff (rst)
    done == $past(accept && !rst)) else $error("done does not track accepted transaction");

  // Overflow is only reported while the queue is full.
  a_over_full: assert property (@(posedge clk) disable iff (rst)
    (done && status == deq_pkg::ST_OVER) |-> is_full)
    else $error("overflow reported on a queue that is not full");

  // Underflow is only reported on an empty queue.
  a_under_empty: assert property (@(posedge clk) disable iff (rst)
    (done && status == deq_pkg::ST_UNDER) |-> is_empty)
    else $error("underflow reported on a queue that is not empty");

  // A transaction that changes the queue moves the count by exactly one.
  a_count_step: assert property (@(posedge clk) disable iff (rst)
    (accept && count_next != count) |=>
      (count == $past(count) + OneC || count == $past(count) - OneC))
    else $error("count changed by more than one");

endmodule

// File: rtl/deq_cell.sv
// One storage cell of the queue chain, holding a single entry.
module deq_cell #(
  parameter int VALUE_WIDTH = deq_pkg::DefaultValueWidth,
  parameter int CNT_W = 5,
  parameter int IDX = 0
) (
  input  logic                   clk,
  input  deq_pkg::cell_ctl_t     ctl,
  input  logic [CNT_W-1:0]       count,
  input  logic [VALUE_WIDTH-1:0] push_value,
  input  logic [VALUE_WIDTH-1:0] prev_value,
  input  logic [VALUE_WIDTH-1:0] next_value,
  output logic [VALUE_WIDTH-1:0] value,
  output logic [VALUE_WIDTH-1:0] tap
);

  localparam logic [CNT_W-1:0] IdxC = CNT_W'(IDX);
  localparam logic [CNT_W-1:0] IdxNext = CNT_W'(IDX + 1);

  // Entry register: shifts toward the back on a front push, toward the
  // front on a front pop, and loads the value when it is the first free cell
  // on a back push. Otherwise the entry holds.
  always_ff @(posedge clk) begin
    priority if (ctl.push_front) begin
      value <= (IDX == 0) ? push_value : prev_value;
    end else if (ctl.pop_front) begin
      value <= next_value;
    end else if (ctl.push_back && (count == IdxC)) begin
      value <= push_value;
    end else begin
      value <= value;
    end
  end

  // This cell drives the back tap when it holds the last entry.
  assign tap = (count == IdxNext) ? value : '0;

endmodule
